### src/cau_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cau_pkg: shared definitions for the complex arithmetic unit
// Action codes, internal operation classes and default widths.
// ============================================================================
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_CMP = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_CMP,
		OP_NONE
	} op_t;

	localparam int OP_BITS = $bits(op_t);

endpackage

### src/cau_front.sv
`timescale 1ns / 1ps
// ============================================================================
// cau_front: command intake
// Registers an accepted command and classifies its action code.
// ============================================================================
module cau_front import cau_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           action,
	input  logic signed [DW-1:0] a_re,
	input  logic signed [DW-1:0] a_im,
	input  logic signed [DW-1:0] b_re,
	input  logic signed [DW-1:0] b_im,
	input  logic                 q_full,
	output logic                 push,
	output op_t                  op,
	output logic signed [DW-1:0] ar,
	output logic signed [DW-1:0] ai,
	output logic signed [DW-1:0] br,
	output logic signed [DW-1:0] bi
);

	logic v_q;
	op_t  op_dec;

	always_comb begin
		unique case (action)
			ACT_ADD: op_dec = OP_ADD;
			ACT_SUB: op_dec = OP_SUB;
			ACT_MUL: op_dec = OP_MUL;
			ACT_DIV: op_dec = OP_DIV;
			ACT_CMP: op_dec = OP_CMP;
			default: op_dec = OP_NONE;
		endcase
	end

	assign busy = v_q && q_full;
	assign push = v_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!busy) begin
			v_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op <= op_dec;
			ar <= a_re;
			ai <= a_im;
			br <= b_re;
			bi <= b_im;
		end
	end

endmodule

### src/cau_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// cau_queue: short command queue
// Decouples command intake from execution.
// ============================================================================
module cau_queue import cau_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

### src/cau_back.sv
`timescale 1ns / 1ps
// ============================================================================
// cau_back: execution datapath
// Product stage, finishing stage and a bit-serial two-lane divider.
// ============================================================================
module cau_back import cau_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF,
	parameter int FB = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  op_t                  op,
	input  logic signed [DW-1:0] ar,
	input  logic signed [DW-1:0] ai,
	input  logic signed [DW-1:0] br,
	input  logic signed [DW-1:0] bi,
	output logic                 done,
	output logic signed [DW-1:0] res_re,
	output logic signed [DW-1:0] res_im,
	output logic                 status,
	output logic                 saturated,
	output logic                 is_smaller
);

	localparam int PW   = 2 * DW;
	localparam int SW   = PW + 1;
	localparam int NB   = PW + FB;
	localparam int DENW = PW + 1;
	localparam int CW   = $clog2(NB + 1);
	localparam logic [NB-1:0] LIM = NB'(1) << (DW - 1);

	function automatic logic [PW-1:0] mag_of(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		t = v[SW-1] ? -v : v;
		return t[PW-1:0];
	endfunction

	// Returns the saturation flag above the encoded value.
	function automatic logic [DW:0] sat_enc(input logic neg, input logic [NB-1:0] mag);
		logic [NB-1:0] t;
		t = ~mag + 1'b1;
		if (neg) begin
			if (mag > LIM) begin
				return {1'b1, 1'b1, {(DW-1){1'b0}}};
			end
			return {1'b0, t[DW-1:0]};
		end
		if (mag > LIM - 1'b1) begin
			return {1'b1, 1'b0, {(DW-1){1'b1}}};
		end
		return {1'b0, mag[DW-1:0]};
	endfunction

	// Product stage registers.
	logic                 v_s1;
	op_t                  op_s1;
	logic signed [DW:0]   sre_s1, sim_s1;
	logic signed [PW-1:0] prr_s1, pii_s1, pri_s1, pir_s1;
	logic signed [PW-1:0] sqar_s1, sqai_s1, sqbr_s1, sqbi_s1;

	// Divider registers.
	logic                 div_busy_q;
	logic [CW-1:0]        cnt_q;
	logic [NB-1:0]        dq_re_q, dq_im_q;
	logic [DENW-1:0]      rem_re_q, rem_im_q, den_q;
	logic                 dneg_re_q, dneg_im_q;

	logic                 leave;
	logic signed [SW-1:0] mre, mim, dre, dim, sre_w, sim_w;
	logic [DENW-1:0]      den, ma, mb;
	logic [PW-1:0]        abs_re, abs_im;
	logic                 neg_re, neg_im;
	logic [NB-1:0]        fmag_re, fmag_im;
	logic [DW:0]          enc_re, enc_im;
	logic                 f_status, f_smaller, f_we, div_load;

	logic [DENW:0]        t_re, t_im;
	logic                 ge_re, ge_im;
	logic [DENW:0]        nr_re, nr_im;
	logic [DW:0]          qenc_re, qenc_im;

	assign leave    = v_s1 && !div_busy_q;
	assign in_ready = !v_s1 || leave;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			sre_s1  <= (op == OP_SUB) ? ar - br : ar + br;
			sim_s1  <= (op == OP_SUB) ? ai - bi : ai + bi;
			prr_s1  <= ar * br;
			pii_s1  <= ai * bi;
			pri_s1  <= ar * bi;
			pir_s1  <= ai * br;
			sqar_s1 <= ar * ar;
			sqai_s1 <= ai * ai;
			sqbr_s1 <= br * br;
			sqbi_s1 <= bi * bi;
		end
	end

	assign mre   = prr_s1 - pii_s1;
	assign mim   = pri_s1 + pir_s1;
	assign dre   = prr_s1 + pii_s1;
	assign dim   = pir_s1 - pri_s1;
	assign sre_w = SW'(sre_s1);
	assign sim_w = SW'(sim_s1);
	assign den   = DENW'(sqbr_s1) + DENW'(sqbi_s1);
	assign ma    = DENW'(sqar_s1) + DENW'(sqai_s1);
	assign mb    = DENW'(sqbr_s1) + DENW'(sqbi_s1);

	always_comb begin
		abs_re    = '0;
		abs_im    = '0;
		neg_re    = 1'b0;
		neg_im    = 1'b0;
		fmag_re   = '0;
		fmag_im   = '0;
		f_status  = 1'b0;
		f_smaller = 1'b0;
		case (op_s1) inside
			OP_ADD, OP_SUB: begin
				abs_re  = mag_of(sre_w);
				abs_im  = mag_of(sim_w);
				neg_re  = sre_w[SW-1];
				neg_im  = sim_w[SW-1];
				fmag_re = NB'(abs_re);
				fmag_im = NB'(abs_im);
			end
			OP_MUL: begin
				abs_re  = mag_of(mre) >> FB;
				abs_im  = mag_of(mim) >> FB;
				neg_re  = mre[SW-1] && (abs_re != '0);
				neg_im  = mim[SW-1] && (abs_im != '0);
				fmag_re = NB'(abs_re);
				fmag_im = NB'(abs_im);
			end
			OP_DIV: begin
				f_status = (den == '0);
			end
			OP_CMP: begin
				f_smaller = (ma < mb);
			end
			default: begin
			end
		endcase
	end

	assign enc_re   = sat_enc(neg_re, fmag_re);
	assign enc_im   = sat_enc(neg_im, fmag_im);
	assign div_load = leave && (op_s1 == OP_DIV) && (den != '0);
	assign f_we     = leave && !div_load;

	// Restoring division, one quotient bit per lane and cycle.
	assign t_re    = {rem_re_q, dq_re_q[NB-1]};
	assign t_im    = {rem_im_q, dq_im_q[NB-1]};
	assign ge_re   = (t_re >= {1'b0, den_q});
	assign ge_im   = (t_im >= {1'b0, den_q});
	assign nr_re   = ge_re ? t_re - {1'b0, den_q} : t_re;
	assign nr_im   = ge_im ? t_im - {1'b0, den_q} : t_im;
	assign qenc_re = sat_enc(dneg_re_q && (dq_re_q != '0), dq_re_q);
	assign qenc_im = sat_enc(dneg_im_q && (dq_im_q != '0), dq_im_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			cnt_q      <= '0;
			done       <= 1'b0;
		end else begin
			done <= f_we || (div_busy_q && cnt_q == '0);
			if (div_load) begin
				div_busy_q <= 1'b1;
				cnt_q      <= CW'(NB);
			end else if (div_busy_q) begin
				if (cnt_q == '0) begin
					div_busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			dq_re_q   <= NB'(mag_of(dre)) << FB;
			dq_im_q   <= NB'(mag_of(dim)) << FB;
			rem_re_q  <= '0;
			rem_im_q  <= '0;
			den_q     <= den;
			dneg_re_q <= dre[SW-1];
			dneg_im_q <= dim[SW-1];
		end else if (div_busy_q && cnt_q != '0) begin
			dq_re_q  <= {dq_re_q[NB-2:0], ge_re};
			dq_im_q  <= {dq_im_q[NB-2:0], ge_im};
			rem_re_q <= nr_re[DENW-1:0];
			rem_im_q <= nr_im[DENW-1:0];
		end
		if (f_we) begin
			res_re     <= enc_re[DW-1:0];
			res_im     <= enc_im[DW-1:0];
			saturated  <= enc_re[DW] || enc_im[DW];
			status     <= f_status;
			is_smaller <= f_smaller;
		end else if (div_busy_q && cnt_q == '0) begin
			res_re     <= qenc_re[DW-1:0];
			res_im     <= qenc_im[DW-1:0];
			saturated  <= qenc_re[DW] || qenc_im[DW];
			status     <= 1'b0;
			is_smaller <= 1'b0;
		end
	end

endmodule

### src/complex_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ============================================================================
// complex_arithmetic_unit_core: complex add, subtract, multiply, divide, compare
// Signed fixed-point complex arithmetic with saturation and divide-by-zero status.
// ============================================================================
// Usage. A command beat is taken at a rising edge where start is high and busy
// is low; it carries action and the operands a_re, a_im, b_re, b_im. Each command
// yields exactly one result beat, shown for one cycle with done high, in command
// order. The receiver cannot stall, so results are never held back.
// Commands pass through an intake register and a short queue into the execution
// path, so intake keeps accepting while the back end works.
// Add, subtract, multiply, compare and divide-by-zero pass the intake register,
// the queue, the product stage and the result registers, and sustain one command
// per cycle while no divide is in flight. A divide with a nonzero divisor runs a
// restoring divider, one quotient bit per cycle for both parts at once, over
// 2*DATA_WIDTH+FRAC_BITS iterations and a finishing step; it sets the rate while
// in flight, later commands wait behind it, and busy rises once the queue fills.
// Reset clears all valid flags, the queue and the divider; no result is pending
// after reset and busy is low.
// ============================================================================
module complex_arithmetic_unit_core import cau_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         status,
	output logic                         saturated,
	output logic                         is_smaller
);

	localparam int DW = DATA_WIDTH;
	localparam int QW = OP_BITS + 4 * DW;

	// Intake to queue.
	logic                 q_full;
	logic                 push;
	op_t                  f_op;
	logic signed [DW-1:0] f_ar, f_ai, f_br, f_bi;

	// Queue to execution.
	logic                 q_valid;
	logic                 q_pop;
	logic [QW-1:0]        q_wdata, q_rdata;
	op_t                  x_op;

	cau_front #(.DW(DW)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.action (action),
		.a_re   (a_re),
		.a_im   (a_im),
		.b_re   (b_re),
		.b_im   (b_im),
		.q_full (q_full),
		.push   (push),
		.op     (f_op),
		.ar     (f_ar),
		.ai     (f_ai),
		.br     (f_br),
		.bi     (f_bi)
	);

	assign q_wdata = {f_op, f_ar, f_ai, f_br, f_bi};

	cau_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rdata     (q_rdata)
	);

	// The op code occupies the top bits of each queue entry.
	assign x_op = op_t'(q_rdata[QW-1 -: OP_BITS]);

	cau_back #(.DW(DW), .FB(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (q_pop),
		.op         (x_op),
		.ar         (q_rdata[4*DW-1 -: DW]),
		.ai         (q_rdata[3*DW-1 -: DW]),
		.br         (q_rdata[2*DW-1 -: DW]),
		.bi         (q_rdata[DW-1 -: DW]),
		.done       (done),
		.res_re     (res_re),
		.res_im     (res_im),
		.status     (status),
		.saturated  (saturated),
		.is_smaller (is_smaller)
	);

endmodule

### verif/complex_arithmetic_unit_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// complex_arithmetic_unit_core_tb: self-checking bench for the complex unit
// Sends add, subtract, multiply, divide, compare and unused action beats, with
// corner operands, zero divisors and random traffic. Every result beat is
// checked field by field against an in-bench fixed-point predictor, in order.
// ============================================================================
module complex_arithmetic_unit_core_tb import cau_pkg::*; ();

	localparam int W = DATA_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int RANDOM_BEATS = 1400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST = 3'd7;
	localparam longint MAX_Q = (64'sd1 <<< (W - 1)) - 1;
	localparam longint MIN_Q = -(64'sd1 <<< (W - 1));

	typedef struct packed {
		logic signed [W-1:0] re;
		logic signed [W-1:0] im;
		logic status;
		logic saturated;
		logic is_smaller;
	} cplx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] action = ACT_ADD;
	logic signed [W-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic done;
	logic signed [W-1:0] res_re, res_im;
	logic status, saturated, is_smaller;

	cplx_result_t pending_results[$];
	int mismatches = 0;
	int beats_sent = 0;
	int results_checked = 0;
	int divides_sent = 0;
	int cycles = 0;
	bit allow_idle = 1'b1;

	complex_arithmetic_unit_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
		.res_re(res_re), .res_im(res_im), .status(status), .saturated(saturated),
		.is_smaller(is_smaller)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Clamp a wide value into the result range and note any clamping.
	function automatic logic signed [W-1:0] clamp_q(input longint v, inout bit sat);
		if (v > MAX_Q) begin
			sat = 1'b1;
			return MAX_Q[W-1:0];
		end
		if (v < MIN_Q) begin
			sat = 1'b1;
			return MIN_Q[W-1:0];
		end
		return v[W-1:0];
	endfunction

	// Fixed-point complex operation. Integer division in SystemVerilog truncates
	// toward zero, which is the rounding the unit uses for products and quotients.
	function automatic cplx_result_t complex_op(input logic [2:0] act,
			input longint ar, input longint ai, input longint br, input longint bi);
		cplx_result_t r;
		bit sat;
		longint pre, pim, den;
		r = '0;
		sat = 1'b0;
		case (act) inside
			ACT_ADD, ACT_SUB: begin
				if (act == ACT_SUB) begin
					br = -br;
					bi = -bi;
				end
				r.re = clamp_q(ar + br, sat);
				r.im = clamp_q(ai + bi, sat);
			end
			ACT_MUL: begin
				pre = (ar * br - ai * bi) / (64'sd1 <<< FB);
				pim = (ar * bi + ai * br) / (64'sd1 <<< FB);
				r.re = clamp_q(pre, sat);
				r.im = clamp_q(pim, sat);
			end
			ACT_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.status = 1'b1;
				end else begin
					pre = ((ar * br + ai * bi) * (64'sd1 <<< FB)) / den;
					pim = ((ai * br - ar * bi) * (64'sd1 <<< FB)) / den;
					r.re = clamp_q(pre, sat);
					r.im = clamp_q(pim, sat);
				end
			end
			ACT_CMP: begin
				r.is_smaller = (ar * ar + ai * ai) < (br * br + bi * bi);
			end
			default: begin
			end
		endcase
		r.saturated = sat;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch on result %0d: %s got %0d expected %0d",
			results_checked, what, got, want);
	endtask

	// Drive one command beat and hold it until the unit takes it. Inputs move on
	// the falling edge; acceptance is judged from busy as seen at the rising edge.
	task automatic send_beat(input logic [2:0] act, input logic signed [W-1:0] ar,
			input logic signed [W-1:0] ai, input logic signed [W-1:0] br,
			input logic signed [W-1:0] bi);
		@(negedge clk);
		while (allow_idle && $urandom_range(99) < 14) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		action = act;
		a_re = ar;
		a_im = ai;
		b_re = br;
		b_im = bi;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_results.push_back(complex_op(act, ar, ai, br, bi));
		beats_sent++;
		if (act == ACT_DIV)
			divides_sent++;
	endtask

	// Results cannot be held off, so every done cycle is compared immediately.
	always @(posedge clk) begin
		cplx_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (res_re !== want.re)
					report_mismatch("res_re", res_re, want.re);
				if (res_im !== want.im)
					report_mismatch("res_im", res_im, want.im);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (saturated !== want.saturated)
					report_mismatch("saturated", saturated, want.saturated);
				if (is_smaller !== want.is_smaller)
					report_mismatch("is_smaller", is_smaller, want.is_smaller);
			end
			results_checked++;
		end
	end

	// A hung unit ends the run here rather than spinning forever.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// All actions and spare codes, all operands most negative, then a_im most
	// negative and the rest most positive. These hit each saturation direction.
	task automatic test_corner_operands();
		for (int a = ACT_ADD; a <= ACT_SPARE_LAST; a++) begin
			send_beat(a[2:0], MIN_Q[W-1:0], MIN_Q[W-1:0], MIN_Q[W-1:0], MIN_Q[W-1:0]);
			send_beat(a[2:0], MAX_Q[W-1:0], MIN_Q[W-1:0], MAX_Q[W-1:0], MAX_Q[W-1:0]);
		end
	endtask

	// A zero divisor must give zero parts and the divide-by-zero status.
	task automatic test_zero_divisor();
		send_beat(ACT_DIV, 16'sd256, -16'sd512, '0, '0);
		send_beat(ACT_DIV, MIN_Q[W-1:0], MAX_Q[W-1:0], '0, '0);
	endtask

	// Equal and unequal compares; divides by a tiny (overflowing) and a huge divisor.
	task automatic test_compare_and_tiny_divisor();
		send_beat(ACT_CMP, 16'sd3, 16'sd4, -16'sd4, 16'sd3);
		send_beat(ACT_CMP, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
		send_beat(ACT_DIV, MAX_Q[W-1:0], MAX_Q[W-1:0], 16'sd1, '0);
		send_beat(ACT_DIV, -16'sd1, 16'sd1, MIN_Q[W-1:0], MAX_Q[W-1:0]);
	endtask

	function automatic logic signed [W-1:0] pick_operand();
		case ($urandom_range(9)) inside
			0: return MAX_Q[W-1:0];
			1: return MIN_Q[W-1:0];
			2: return '0;
			3, 4: return W'(int'($urandom_range(1023)) - 512);
			default: return W'($urandom());
		endcase
	endfunction

	// Random traffic, mostly the five real actions, with a stretch of beats sent
	// back to back so the intake queue and busy are exercised under full load.
	task automatic test_random_traffic();
		logic [2:0] act;
		logic signed [W-1:0] br, bi;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			allow_idle = !(n >= 500 && n < 800);
			if ($urandom_range(99) < 5)
				act = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
			else
				act = 3'($urandom_range(ACT_CMP, ACT_ADD));
			br = pick_operand();
			bi = pick_operand();
			if (act == ACT_DIV && $urandom_range(19) == 0) begin
				br = '0;
				bi = '0;
			end
			send_beat(act, pick_operand(), pick_operand(), br, bi);
		end
		allow_idle = 1'b1;
		@(negedge clk);
		start = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_corner_operands();
		test_zero_divisor();
		test_compare_and_tiny_divisor();
		test_random_traffic();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d command beats (%0d divides), checked %0d result beats.",
			beats_sent, divides_sent, results_checked);
		$display("Covered all actions, spare codes, saturation and zero divisors.");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sim.f
src/cau_pkg.sv
src/cau_front.sv
src/cau_queue.sv
src/cau_back.sv
src/complex_arithmetic_unit_core.sv
verif/complex_arithmetic_unit_core_tb.sv
